// File: design/odr332_pkg.sv
// Shared types, constants and threshold tables for the RGB332 ordered dither core.
// No dependencies; imported by odr332_luma and ordered_dither_rgb332_core.
`default_nettype none

package odr332_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DITHER_ON = 2'd0;
  localparam logic [1:0] CFG_GRAY_ON   = 2'd1;

  // Luma weights; the sum is divided by 255 afterwards.
  localparam logic [5:0] LUMA_W_RED   = 6'd54;
  localparam logic [7:0] LUMA_W_GREEN = 8'd182;
  localparam logic [4:0] LUMA_W_BLUE  = 5'd19;

  // Load enables of the three luma pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Threshold for red and green, indexed by {row, col}.
  function automatic logic [4:0] thr_rg(input logic [3:0] idx);
    logic [4:0] t;
    case (idx)
      4'd0:    t = 5'd2;
      4'd1:    t = 5'd17;
      4'd2:    t = 5'd6;
      4'd3:    t = 5'd21;
      4'd4:    t = 5'd24;
      4'd5:    t = 5'd9;
      4'd6:    t = 5'd28;
      4'd7:    t = 5'd13;
      4'd8:    t = 5'd8;
      4'd9:    t = 5'd23;
      4'd10:   t = 5'd4;
      4'd11:   t = 5'd19;
      4'd12:   t = 5'd30;
      4'd13:   t = 5'd15;
      4'd14:   t = 5'd26;
      4'd15:   t = 5'd11;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // Threshold for blue, indexed by {row, col}.
  function automatic logic [5:0] thr_b(input logic [3:0] idx);
    logic [5:0] t;
    case (idx)
      4'd0:    t = 6'd4;
      4'd1:    t = 6'd34;
      4'd2:    t = 6'd11;
      4'd3:    t = 6'd41;
      4'd4:    t = 6'd49;
      4'd5:    t = 6'd19;
      4'd6:    t = 6'd56;
      4'd7:    t = 6'd26;
      4'd8:    t = 6'd15;
      4'd9:    t = 6'd45;
      4'd10:   t = 6'd8;
      4'd11:   t = 6'd38;
      4'd12:   t = 6'd60;
      4'd13:   t = 6'd30;
      4'd14:   t = 6'd53;
      4'd15:   t = 6'd23;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: design/ordered_dither_rgb332_core.sv
// Top level of the RGB332 ordered dither core: handshakes, config and final stage.
// Depends on odr332_pkg and odr332_luma.
`default_nettype none

// Usage:
// Pixels enter on the input channel (in_valid_i/in_ready_o) with their 8-bit
// red, green and blue channels and the 10-bit screen coordinates. Each item
// yields one packed BBGGGRRR byte on the output channel (out_valid_o/out_ready_i).
// The pipeline has four register stages: weighted luma products, their sum,
// the division by 255, and the dither add with packing into the output register.
// Items pass the stages in that order. One item can be accepted in every cycle
// while the output is not stalled, so throughput is one pixel per clock.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes dither_on at
// index 0 and gray_on at index 1; bit cfg_data_i is stored, other indexes are
// ignored. It is always ready and should be written only while the pipeline
// is empty. The mode bits are sampled with each item as it enters.
// Reset clears all stage valid bits and sets dither_on to 1, gray_on to 0.
// When the receiver stalls, each stage holds its item until the stage after it
// frees up; bubbles are squeezed out, and in_ready_o drops only once every
// stage holds an item.

module ordered_dither_rgb332_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic       cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic [9:0] x_pos_i,
  input  wire logic [9:0] y_pos_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      packed_pixel_o
);
  import odr332_pkg::*;

  // Configuration registers.
  logic dither_on_q, gray_on_q;

  // Per-stage valid bits and advance conditions.
  logic [3:0] vld_q;
  logic [3:0] adv;

  // Side data carried alongside the luma pipeline, one entry per stage 1..3.
  logic [23:0] rgb_q [3];
  logic [3:0]  idx_q [3];
  logic        dith_q [3];
  logic        gray_q [3];

  logic [7:0]  luma;
  logic [7:0]  pix_q, pix_d;
  stage_en_t   luma_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_on_q <= 1'b1;
      gray_on_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DITHER_ON: dither_on_q <= cfg_data_i;
        CFG_GRAY_ON:   gray_on_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // A stage may load when it is empty or when its item moves on.
  always_comb begin
    adv[3] = !vld_q[3] || out_ready_i;
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  assign luma_en = '{s1: adv[0], s2: adv[1], s3: adv[2]};

  odr332_luma u_luma (
    .clk_i   (clk_i),
    .en_i    (luma_en),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .luma_o  (luma)
  );

  // The matrix row comes from x and the column from y.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rgb_q[0]  <= {red_i, green_i, blue_i};
      idx_q[0]  <= {x_pos_i[1:0], y_pos_i[1:0]};
      dith_q[0] <= dither_on_q;
      gray_q[0] <= gray_on_q;
    end
    if (adv[1]) begin
      rgb_q[1]  <= rgb_q[0];
      idx_q[1]  <= idx_q[0];
      dith_q[1] <= dith_q[0];
      gray_q[1] <= gray_q[0];
    end
    if (adv[2]) begin
      rgb_q[2]  <= rgb_q[1];
      idx_q[2]  <= idx_q[1];
      dith_q[2] <= dith_q[1];
      gray_q[2] <= gray_q[1];
    end
    if (adv[3]) begin
      pix_q <= pix_d;
    end
  end

  // Final stage: pick luma or color, add the threshold with saturation, pack.
  always_comb begin
    logic [7:0] r, g, b;
    logic [5:0] t_rg, t_b;
    logic [8:0] sr, sg, sb;
    logic [7:0] dr, dg, db;
    if (gray_q[2]) begin
      r = luma;
      g = luma;
      b = luma;
    end else begin
      r = rgb_q[2][23:16];
      g = rgb_q[2][15:8];
      b = rgb_q[2][7:0];
    end
    t_rg = dith_q[2] ? {1'b0, thr_rg(idx_q[2])} : 6'd0;
    t_b  = dith_q[2] ? thr_b(idx_q[2]) : 6'd0;
    sr = {1'b0, r} + {3'd0, t_rg};
    sg = {1'b0, g} + {3'd0, t_rg};
    sb = {1'b0, b} + {3'd0, t_b};
    dr = sr[8] ? 8'hFF : sr[7:0];
    dg = sg[8] ? 8'hFF : sg[7:0];
    db = sb[8] ? 8'hFF : sb[7:0];
    pix_d = {db[7:6], dg[7:5], dr[7:5]};
  end

  assign out_valid_o    = vld_q[3];
  assign packed_pixel_o = pix_q;

endmodule

`default_nettype wire

// File: design/odr332_luma.sv
// Three-stage luma pipeline: weighted products, sum, and division by 255.
// Depends on odr332_pkg for the weights and the stage enable struct.
`default_nettype none

module odr332_luma (
  input  wire logic                  clk_i,
  input  wire odr332_pkg::stage_en_t en_i,
  input  wire logic [7:0]            red_i,
  input  wire logic [7:0]            green_i,
  input  wire logic [7:0]            blue_i,
  output logic [7:0]                 luma_o
);
  import odr332_pkg::*;

  logic [13:0] p_r_q, p_r_d;
  logic [15:0] p_g_q, p_g_d;
  logic [12:0] p_b_q, p_b_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  luma_q, luma_d;
  logic [8:0]  rem;

  always_comb begin
    p_r_d = 14'(red_i * LUMA_W_RED);
    p_g_d = 16'(green_i * LUMA_W_GREEN);
    p_b_d = 13'(blue_i * LUMA_W_BLUE);
    sum_d = 16'(p_r_q) + p_g_q + 16'(p_b_q);
    // s/255 is s>>8 or one more; the remainder against s>>8 stays below 510.
    rem    = {1'b0, sum_q[7:0]} + {1'b0, sum_q[15:8]};
    luma_d = sum_q[15:8] + {7'd0, (rem >= 9'd255)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p_r_q <= p_r_d;
      p_g_q <= p_g_d;
      p_b_q <= p_b_d;
    end
    if (en_i.s2) begin
      sum_q <= sum_d;
    end
    if (en_i.s3) begin
      luma_q <= luma_d;
    end
  end

  assign luma_o = luma_q;

endmodule

`default_nettype wire

// File: dv/ordered_dither_rgb332_core_tb.sv
// Self-checking testbench for ordered_dither_rgb332_core: pixels in, packed RGB332 bytes out.
// Depends on odr332_pkg for the register indexes and on the core itself; nothing else.
// A scoreboard class predicts every byte from the pixel and the mode bits it holds.

module ordered_dither_rgb332_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import odr332_pkg::*;

  // The core has four register stages; the settle wait after draining covers any straggler.
  localparam int PIPE_LATENCY   = 4;
  localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_PIXELS   = 175;
  localparam int HOLD_OFF_LEN   = 60;

  // Register indexes that the core does not decode; writes to them must be dropped.
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  // One pixel as it crosses the input channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] x_pos;
    logic [9:0] y_pos;
  } pixel_t;

  // The scoreboard keeps its own copy of the two mode bits and a queue of the
  // bytes that the core still owes, in order of acceptance.
  class rgb332_scoreboard;
    bit          dither_on;
    bit          gray_on;
    logic [7:0]  pending_bytes[$];
    int unsigned errors;
    int unsigned checked;
    bit [4:0]    rg_thresh[4][4];
    bit [5:0]    b_thresh[4][4];

    function new();
      dither_on = 1'b1;
      gray_on   = 1'b0;
      errors    = 0;
      checked   = 0;
      rg_thresh = '{'{2, 17, 6, 21}, '{24, 9, 28, 13}, '{8, 23, 4, 19}, '{30, 15, 26, 11}};
      b_thresh  = '{'{4, 34, 11, 41}, '{49, 19, 56, 26}, '{15, 45, 8, 38}, '{60, 30, 53, 23}};
    endfunction

    // Mirrors a write on the configuration channel; unknown indexes change nothing.
    function void write_reg(logic [1:0] index, logic data);
      case (index)
        CFG_DITHER_ON: dither_on = data;
        CFG_GRAY_ON:   gray_on   = data;
        default:       ;
      endcase
    endfunction

    // Luma if gray_on, then the ordered threshold with saturation if dither_on, then truncation.
    function logic [7:0] dither_to_rgb332(pixel_t p);
      logic [7:0]  r, g, b;
      logic [15:0] luma_sum;
      logic [8:0]  sum_r, sum_g, sum_b;
      logic [1:0]  row, col;
      r = p.red;
      g = p.green;
      b = p.blue;
      if (gray_on) begin
        luma_sum = 16'(r) * 16'd54 + 16'(g) * 16'd182 + 16'(b) * 16'd19;
        r = 8'(luma_sum / 16'd255);
        g = r;
        b = r;
      end
      if (dither_on) begin
        row   = p.x_pos[1:0];
        col   = p.y_pos[1:0];
        sum_r = {1'b0, r} + 9'(rg_thresh[row][col]);
        sum_g = {1'b0, g} + 9'(rg_thresh[row][col]);
        sum_b = {1'b0, b} + 9'(b_thresh[row][col]);
        r = sum_r[8] ? 8'hFF : sum_r[7:0];
        g = sum_g[8] ? 8'hFF : sum_g[7:0];
        b = sum_b[8] ? 8'hFF : sum_b[7:0];
      end
      return {b[7:6], g[7:5], r[7:5]};
    endfunction

    function void note_pixel(pixel_t p);
      pending_bytes.push_back(dither_to_rgb332(p));
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("packed_pixel 0x%02h arrived with no pixel pending", got));
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("result %0d: packed_pixel 0x%02h, predicted 0x%02h",
                                    checked, got, want));
        end
        checked++;
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  pixel_t     in_pixel;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] packed_pixel;

  // Random idling switches per side, and a one-shot request for a long receiver stall.
  bit          send_idle;
  bit          recv_idle;
  int unsigned hold_off;

  rgb332_scoreboard sb;

  ordered_dither_rgb332_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .red_i          (in_pixel.red),
    .green_i        (in_pixel.green),
    .blue_i         (in_pixel.blue),
    .x_pos_i        (in_pixel.x_pos),
    .y_pos_i        (in_pixel.y_pos),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .packed_pixel_o (packed_pixel)
  );

  // 10 ns clock; every input changes on the falling edge, outputs are read on the rising one.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offers one pixel after a gap, random if send_idle is set, and waits until the core
  // takes it. This task drops valid only in a gap, so back-to-back items keep it high throughout.
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk_i); while (!in_ready);
    sb.note_pixel(p);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // A register write; the scoreboard follows it only once the handshake completes.
  task automatic write_reg(logic [1:0] index, logic data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(index, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender back until every predicted byte has come out, then lets the
  // pipeline settle so a following register write finds it empty. The input is
  // released first so the last pixel is not taken a second time.
  task automatic wait_idle();
    release_input();
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly uniform channel values; the rest sit near the ends of the range so that
  // saturation and the zero corner come up often.
  function automatic logic [7:0] rand_channel();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(192, 255));
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  // Result side: draws a random stall per item if recv_idle is set, or takes the long
  // hold-off when asked, and counts that stall in cycles here rather than in the sender.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (hold_off != 0) begin
        stall    = hold_off;
        hold_off = 0;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      sb.check_pixel(packed_pixel);
    end
  end

  initial begin : stimulus
    pixel_t px;
    bit     mode_dither;
    bit     mode_gray;
    cfg_valid = 1'b0;
    cfg_index = CFG_DITHER_ON;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_off  = 0;
    sb        = new();
    rst_ni    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from the reset modes (dither on, gray off). The first
    // sixteen pixels visit every matrix cell, with red and some blue values close
    // enough to the top that the threshold saturates; the coordinates carry set
    // upper bits so that only the low two bits may matter.
    for (int c = 0; c < 16; c++) begin
      send_pixel(pixel_t'{8'(240 + c), 8'(32 + 8 * c), 8'(192 + 4 * c),
                          10'((c >> 2) + 4 * (c * 13)), 10'((c & 3) + 4 * (255 - 16 * c))});
    end
    send_pixel(pixel_t'{8'h00, 8'h00, 8'h00, 10'd0, 10'd0});
    send_pixel(pixel_t'{8'hFF, 8'hFF, 8'hFF, 10'd1023, 10'd1023});
    wait_idle();

    // Truncation only.
    write_reg(CFG_DITHER_ON, 1'b0);
    send_pixel(pixel_t'{8'hFF, 8'hFF, 8'hFF, 10'd1023, 10'd1023});
    send_pixel(pixel_t'{8'h5A, 8'hA5, 8'h3C, 10'd2, 10'd1});
    wait_idle();

    // Gray with dither. The writes to undecoded indexes carry values that would
    // clear either mode bit if the index were decoded on its low bit alone.
    write_reg(CFG_GRAY_ON, 1'b1);
    write_reg(CFG_DITHER_ON, 1'b1);
    write_reg(CFG_SPARE_2, 1'b0);
    write_reg(CFG_SPARE_3, 1'b0);
    send_pixel(pixel_t'{8'hFF, 8'hFF, 8'hFF, 10'd3, 10'd3});
    send_pixel(pixel_t'{8'hFF, 8'h00, 8'h00, 10'd1, 10'd2});
    send_pixel(pixel_t'{8'h00, 8'hFF, 8'h00, 10'd2, 10'd3});
    send_pixel(pixel_t'{8'h00, 8'h00, 8'hFF, 10'd3, 10'd0});
    wait_idle();

    // Random phases: each of the four mode settings comes up twice. Phase 0 runs
    // without idling on either side. Phase 3 keeps the sender busy while the
    // receiver holds off for a long stretch, so the pipeline fills and in_ready
    // drops. Phase 6 pauses the sender halfway until the core has drained.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      mode_dither = ~ph[0];
      mode_gray   = ph[1];
      write_reg(CFG_DITHER_ON, mode_dither);
      write_reg(CFG_GRAY_ON, mode_gray);
      send_idle = (ph != 0) && (ph != 3);
      recv_idle = (ph != 0) && (ph != 5);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (ph == 3 && i == 20) hold_off = HOLD_OFF_LEN;
        if (ph == 6 && i == PHASE_PIXELS / 2) wait_idle();
        px.red   = rand_channel();
        px.green = rand_channel();
        px.blue  = rand_channel();
        px.x_pos = 10'($urandom_range(0, 1023));
        px.y_pos = 10'($urandom_range(0, 1023));
        send_pixel(px);
      end
      release_input();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("ordered_dither_rgb332_core_tb: clean");
    end else begin
      $display("ordered_dither_rgb332_core_tb: errors");
    end
    $finish;
  end

  // A correct run ends well before this watchdog fires even with every gap and stall
  // at its longest; reaching it means the core has hung.
  initial begin : watchdog
    #2_000_000;
    $display("ordered_dither_rgb332_core_tb: errors");
    $finish;
  end

endmodule

// File: files.f
design/odr332_pkg.sv
design/odr332_luma.sv
design/ordered_dither_rgb332_core.sv
dv/ordered_dither_rgb332_core_tb.sv
